// ===== rtl/core/qhs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants for the quantized hardswish pipeline.
// No dependencies; every other file imports this package.

package qhs_pkg;

    // fixed-point fraction bits of both scale registers
    localparam int unsigned SCALE_FRAC_BITS = 24;

    // field and register widths
    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned ZP_W     = 8;
    localparam int unsigned SCALE_W  = 32;
    localparam int unsigned BOUND_W  = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // centered sample and dequantized value
    localparam int unsigned D_W = SAMPLE_W + 1;
    localparam int unsigned X_W = SCALE_W + D_W;

    // curve operands: |x| < 3 and 0 < x + 3 < 6 in Q(F)
    localparam int unsigned A_W = SCALE_FRAC_BITS + 2;
    localparam int unsigned T_W = SCALE_FRAC_BITS + 3;
    localparam int unsigned P_W = A_W + T_W;
    // product shifted down by 2^(F+1) before the divide by three
    localparam int unsigned V_W = P_W - SCALE_FRAC_BITS - 1;

    // divide by three via reciprocal, exact for operands below 2^32
    localparam int unsigned DIV3_W     = 32;
    localparam logic [DIV3_W-1:0] DIV3_MAGIC = 32'hAAAA_AAAB;
    localparam int unsigned DIV3_SHIFT = 33;
    localparam int unsigned Q_W        = V_W + DIV3_W;
    localparam int unsigned CURVE_W    = Q_W - DIV3_SHIFT;

    // hardswish magnitude and its split for the requant multiply
    localparam int unsigned H_W  = X_W - 1;
    localparam int unsigned HL_W = 24;
    localparam int unsigned HH_W = H_W - HL_W;
    localparam int unsigned PL_W = SCALE_W + HL_W;
    localparam int unsigned PH_W = SCALE_W + HH_W;
    localparam int unsigned M_W  = SCALE_W + H_W;
    localparam int unsigned M64_W = 64;

    // rounding point of the requantized product, Q(2F)
    localparam int unsigned RND_SH = 2 * SCALE_FRAC_BITS;
    localparam int unsigned IP_W   = M64_W - RND_SH;
    localparam int unsigned R_W    = IP_W + 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_ZERO_POINT  = 3'd0,
        REG_IN_SCALE       = 3'd1,
        REG_OUT_ZERO_POINT = 3'd2,
        REG_INV_OUT_SCALE  = 3'd3,
        REG_OUT_MIN        = 3'd4,
        REG_OUT_MAX        = 3'd5
    } cfg_idx_t;

    // configuration register set
    typedef struct packed {
        logic [ZP_W-1:0]    in_zero_point;
        logic [SCALE_W-1:0] in_scale;
        logic [ZP_W-1:0]    out_zero_point;
        logic [SCALE_W-1:0] inv_out_scale;
        logic [BOUND_W-1:0] out_min;
        logic [BOUND_W-1:0] out_max;
    } cfg_t;

    // which branch of hardswish applies to x
    typedef enum logic [1:0] {
        CLS_ZERO  = 2'd0,
        CLS_PASS  = 2'd1,
        CLS_CURVE = 2'd2
    } hs_cls_t;

    // dequant stage output
    typedef struct packed {
        hs_cls_t        cls;
        logic           neg;
        logic [A_W-1:0] a;
        logic [T_W-1:0] t;
        logic [H_W-1:0] mag;
    } dq_t;

    // hardswish stage output
    typedef struct packed {
        hs_cls_t        cls;
        logic           neg;
        logic [Q_W-1:0] q;
        logic [H_W-1:0] mag;
    } hs_t;

endpackage

// ===== rtl/core/qhs_dequant.sv =====
`timescale 1ns / 1ps
// Dequantize stages: x = in_scale * (sample - in_zero_point), then branch
// classification and curve operands. Depends on qhs_pkg.

module qhs_dequant import qhs_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] in_sample,
    output logic                out_valid,
    input  logic                out_ready,
    output dq_t                 out_data
);

    localparam logic signed [X_W-1:0] THREE = X_W'(3) << SCALE_FRAC_BITS;

    logic                  v1_reg;
    logic                  v2_reg;
    logic                  adv1;
    logic                  adv2;
    logic signed [X_W-1:0] x_reg;
    logic signed [X_W-1:0] x_next;
    logic signed [D_W-1:0] d;
    logic signed [X_W:0]   prod;
    dq_t                   dq_reg;
    dq_t                   dq_next;
    logic signed [X_W-1:0] x_abs;
    logic signed [X_W-1:0] x_plus3;

    // stage advance: a stage moves when empty or when its consumer moves
    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    // center and scale the sample
    always_comb begin
        d      = $signed({1'b0, in_sample}) - $signed({1'b0, cfg.in_zero_point});
        prod   = $signed({1'b0, cfg.in_scale}) * d;
        x_next = prod[X_W-1:0];
    end

    // classify x against +/-3 and form the curve operands
    always_comb begin
        x_abs   = (x_reg < 0) ? -x_reg : x_reg;
        x_plus3 = x_reg + THREE;
        dq_next.neg = 1'b0;
        dq_next.a   = x_abs[A_W-1:0];
        dq_next.t   = x_plus3[T_W-1:0];
        dq_next.mag = x_reg[H_W-1:0];
        if (x_reg <= -THREE) begin
            dq_next.cls = CLS_ZERO;
        end else if (x_reg >= THREE) begin
            dq_next.cls = CLS_PASS;
        end else begin
            dq_next.cls = CLS_CURVE;
            dq_next.neg = (x_reg < 0);
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= in_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv1 && in_valid) begin
            x_reg <= x_next;
        end
        if (adv2 && v1_reg) begin
            dq_reg <= dq_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = dq_reg;

endmodule

// ===== rtl/core/qhs_hswish.sv =====
`timescale 1ns / 1ps
// Hardswish curve stages: x*(x+3) product, then the divide by 6*2^F done
// as a shift and a reciprocal multiply. Depends on qhs_pkg.

module qhs_hswish import qhs_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  dq_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output hs_t  out_data
);

    logic           v1_reg;
    logic           v2_reg;
    logic           adv1;
    logic           adv2;
    logic [P_W-1:0] p_reg;
    logic [P_W-1:0] p_next;
    hs_cls_t        cls_reg;
    logic           neg_reg;
    logic [H_W-1:0] mag_reg;
    logic [V_W-1:0] v;
    hs_t            hs_reg;
    hs_t            hs_next;

    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    // |x| * (x + 3), exact
    assign p_next = P_W'(in_data.a) * P_W'(in_data.t);

    // floor(p / 2^(F+1)) / 3 by reciprocal multiply
    always_comb begin
        v           = p_reg[P_W-1:SCALE_FRAC_BITS+1];
        hs_next.cls = cls_reg;
        hs_next.neg = neg_reg;
        hs_next.mag = mag_reg;
        hs_next.q   = Q_W'(v) * Q_W'(DIV3_MAGIC);
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= in_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv1 && in_valid) begin
            p_reg   <= p_next;
            cls_reg <= in_data.cls;
            neg_reg <= in_data.neg;
            mag_reg <= in_data.mag;
        end
        if (adv2 && v1_reg) begin
            hs_reg <= hs_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = hs_reg;

endmodule

// ===== rtl/core/qhs_requant.sv =====
`timescale 1ns / 1ps
// Requantize stages: split multiply by inv_out_scale, partial product sum
// with overflow check, round half to even and clamp. Depends on qhs_pkg.

module qhs_requant import qhs_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  hs_t                 in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [BOUND_W-1:0]  out_activation
);

    localparam logic [RND_SH-1:0] HALF = RND_SH'(1) << (RND_SH - 1);

    logic                  v1_reg;
    logic                  v2_reg;
    logic                  v3_reg;
    logic                  adv1;
    logic                  adv2;
    logic                  adv3;
    logic [H_W-1:0]        hmag;
    logic [PL_W-1:0]       pl_reg;
    logic [PH_W-1:0]       ph_reg;
    logic                  neg1_reg;
    logic [M_W-1:0]        m_full;
    logic [M64_W-1:0]      m_reg;
    logic                  ovf_reg;
    logic                  neg2_reg;
    logic [IP_W-1:0]       ip;
    logic [RND_SH-1:0]     fr;
    logic                  fr_nz;
    logic signed [R_W-1:0] base;
    logic                  round_up;
    logic signed [R_W-1:0] r;
    logic [BOUND_W-1:0]    act_reg;
    logic [BOUND_W-1:0]    act_next;

    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    // hardswish magnitude per branch
    always_comb begin
        case (in_data.cls)
            CLS_PASS:  hmag = in_data.mag;
            CLS_CURVE: hmag = H_W'(in_data.q[Q_W-1:DIV3_SHIFT]);
            default:   hmag = '0;
        endcase
    end

    // sum of partial products, full width
    assign m_full = M_W'(pl_reg) + (M_W'(ph_reg) << HL_W);

    // round zp +/- m/2^(2F) half to even, then clamp
    always_comb begin
        ip    = m_reg[M64_W-1:RND_SH];
        fr    = m_reg[RND_SH-1:0];
        fr_nz = (fr != '0);
        if (neg2_reg) begin
            base     = $signed(R_W'(cfg.out_zero_point)) - $signed(R_W'(ip))
                       - $signed(R_W'(fr_nz));
            round_up = (fr_nz && fr < HALF) || (fr == HALF && base[0]);
        end else begin
            base     = $signed(R_W'(cfg.out_zero_point)) + $signed(R_W'(ip));
            round_up = (fr > HALF) || (fr == HALF && base[0]);
        end
        r = base + $signed(R_W'(round_up));
        if (ovf_reg) begin
            r = $signed(R_W'(cfg.out_max));
        end
        if (r < $signed(R_W'(cfg.out_min))) begin
            r = $signed(R_W'(cfg.out_min));
        end
        if (r > $signed(R_W'(cfg.out_max))) begin
            r = $signed(R_W'(cfg.out_max));
        end
        act_next = r[BOUND_W-1:0];
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= in_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (adv3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv1 && in_valid) begin
            pl_reg   <= PL_W'(cfg.inv_out_scale) * PL_W'(hmag[HL_W-1:0]);
            ph_reg   <= PH_W'(cfg.inv_out_scale) * PH_W'(hmag[H_W-1:HL_W]);
            neg1_reg <= in_data.neg;
        end
        if (adv2 && v1_reg) begin
            m_reg    <= m_full[M64_W-1:0];
            ovf_reg  <= (m_full[M_W-1:M64_W] != '0);
            neg2_reg <= neg1_reg;
        end
        if (adv3 && v2_reg) begin
            act_reg <= act_next;
        end
    end

    assign out_valid      = v3_reg;
    assign out_activation = act_reg;

endmodule

// ===== rtl/core/quantized_hardswish_unit.sv =====
`timescale 1ns / 1ps
// Quantized uint8 hardswish: dequantize, hardswish, requantize, round, clamp.
// Seven register stages lie between the input transaction and m_tvalid, the first
// loaded at the accepting edge; one transaction per cycle sustained while m_tready
// is high, set by the seven-stage pipeline with per-stage valid bits.
// Synchronous active-low reset empties the pipeline and restores registers:
// zero points 0, both scales 1.0 (Q8.24), out_min 0, out_max 255.
// Depends on qhs_pkg, qhs_dequant, qhs_hswish, qhs_requant.

module quantized_hardswish_unit import qhs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] sample
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata    // [7:0] activation
);

    cfg_t cfg_reg;
    logic dq_valid;
    logic dq_ready;
    dq_t  dq_data;
    logic hs_valid;
    logic hs_ready;
    hs_t  hs_data;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.in_zero_point  <= '0;
            cfg_reg.in_scale       <= SCALE_W'(1) << SCALE_FRAC_BITS;
            cfg_reg.out_zero_point <= '0;
            cfg_reg.inv_out_scale  <= SCALE_W'(1) << SCALE_FRAC_BITS;
            cfg_reg.out_min        <= '0;
            cfg_reg.out_max        <= '1;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                REG_IN_ZERO_POINT:  cfg_reg.in_zero_point  <= cfg_data[ZP_W-1:0];
                REG_IN_SCALE:       cfg_reg.in_scale       <= cfg_data[SCALE_W-1:0];
                REG_OUT_ZERO_POINT: cfg_reg.out_zero_point <= cfg_data[ZP_W-1:0];
                REG_INV_OUT_SCALE:  cfg_reg.inv_out_scale  <= cfg_data[SCALE_W-1:0];
                REG_OUT_MIN:        cfg_reg.out_min        <= cfg_data[BOUND_W-1:0];
                REG_OUT_MAX:        cfg_reg.out_max        <= cfg_data[BOUND_W-1:0];
                default: ;
            endcase
        end
    end

    // dequantize and classify
    qhs_dequant u_dequant (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (s_tdata),
        .out_valid (dq_valid),
        .out_ready (dq_ready),
        .out_data  (dq_data)
    );

    // hardswish curve
    qhs_hswish u_hswish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dq_valid),
        .in_ready  (dq_ready),
        .in_data   (dq_data),
        .out_valid (hs_valid),
        .out_ready (hs_ready),
        .out_data  (hs_data)
    );

    // requantize, round and clamp
    qhs_requant u_requant (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .in_valid       (hs_valid),
        .in_ready       (hs_ready),
        .in_data        (hs_data),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_activation (m_tdata)
    );

endmodule

// ===== tb/tb_quantized_hardswish_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for quantized_hardswish_unit: streams uint8 samples
// under several register settings and compares every activation with a local
// fixed-point predictor. Depends on qhs_pkg and quantized_hardswish_unit.

module tb_quantized_hardswish_unit;
    import qhs_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400_000;
    localparam int unsigned DRAIN_CYCLES  = 20;
    localparam int unsigned HOLD_OFF_LEN  = 150;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned RND_SHIFT     = 2 * SCALE_FRAC_BITS;
    localparam longint      THREE_Q       = longint'(3) <<< SCALE_FRAC_BITS;
    localparam logic [SCALE_W-1:0] SCALE_ONE  = 32'h0100_0000;
    localparam logic [SCALE_W-1:0] SCALE_HALF = 32'h0080_0000;
    localparam logic [SCALE_W-1:0] SCALE_MAX  = 32'hFFFF_FFFF;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    localparam cfg_t RESET_CFG = '{
        in_zero_point:  8'd0,
        in_scale:       SCALE_ONE,
        out_zero_point: 8'd0,
        inv_out_scale:  SCALE_ONE,
        out_min:        8'd0,
        out_max:        8'd255
    };

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic [7:0]          activation;
    } activation_check_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;  // [7:0] sample
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;         // [7:0] activation

    cfg_t              active_cfg = RESET_CFG;
    activation_check_t pending_activations[$];

    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_idle_pct = 0;
    int unsigned hold_off_requests = 0;
    int unsigned cycle_count       = 0;
    int unsigned mismatch_count    = 0;
    int unsigned samples_sent      = 0;
    int unsigned results_checked   = 0;
    int unsigned settings_applied  = 0;

    quantized_hardswish_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // dequantize, hardswish, requantize, round half to even, clamp
    function automatic logic [7:0] quantized_hardswish(input logic [SAMPLE_W-1:0] sample,
                                                       input cfg_t c);
        longint    centered, zp_in, scale_in, x, zp_out, int_part, level, lo, hi;
        bit [63:0] a, t, halfp, hmag, m, frac, frac_mask, half_lsb, three_u;
        bit [127:0] wide;
        bit        neg;
        frac_mask = (64'd1 << RND_SHIFT) - 64'd1;
        half_lsb  = 64'd1 << (RND_SHIFT - 1);
        three_u   = THREE_Q;
        centered  = sample;
        zp_in     = c.in_zero_point;
        scale_in  = c.in_scale;
        x         = (centered - zp_in) * scale_in;
        neg       = 1'b0;
        hmag      = 64'd0;
        // the curve only matters for |x| < 3, magnitude truncated toward zero
        if (x >= THREE_Q) begin
            hmag = x;
        end else if (x > -THREE_Q) begin
            t     = x + THREE_Q;
            a     = (x < 0) ? -x : x;
            halfp = a * (t >> 1) + (t[0] ? (a >> 1) : 64'd0);
            hmag  = halfp / three_u;
            neg   = (x < 0);
        end
        wide   = hmag;
        wide   = wide * c.inv_out_scale;
        zp_out = c.out_zero_point;
        if (wide[127:64] != 0) begin
            // product beyond 64 bits saturates high
            level = c.out_max;
        end else begin
            m        = wide[63:0];
            int_part = m >> RND_SHIFT;
            frac     = m & frac_mask;
            if (neg && m != 0) begin
                level = zp_out - int_part;
                if (frac != 0) begin
                    level -= 1;
                    frac = (frac_mask + 64'd1) - frac;
                end
            end else begin
                level = zp_out + int_part;
            end
            if (frac > half_lsb || (frac == half_lsb && level[0]))
                level += 1;
        end
        // lower bound first, so inverted bounds give out_max
        lo = c.out_min;
        hi = c.out_max;
        if (level < lo) level = lo;
        if (level > hi) level = hi;
        return level[7:0];
    endfunction

    // one register write per cycle, wr_en left high for back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        case (index)
            REG_IN_ZERO_POINT:  active_cfg.in_zero_point  = value[ZP_W-1:0];
            REG_IN_SCALE:       active_cfg.in_scale       = value[SCALE_W-1:0];
            REG_OUT_ZERO_POINT: active_cfg.out_zero_point = value[ZP_W-1:0];
            REG_INV_OUT_SCALE:  active_cfg.inv_out_scale  = value[SCALE_W-1:0];
            REG_OUT_MIN:        active_cfg.out_min        = value[BOUND_W-1:0];
            REG_OUT_MAX:        active_cfg.out_max        = value[BOUND_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // stop offering and wait for every outstanding activation
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_activations.size() != 0)
            @(posedge aclk);
    endtask

    // full register set; 8-bit registers optionally carry junk above their width
    task automatic apply_config(input cfg_t c, input bit junk_upper);
        logic [CFG_DATA_W-1:0] junk;
        wait_idle();
        junk = junk_upper ? ($urandom() & 32'hFFFF_FF00) : '0;
        write_reg(REG_IN_ZERO_POINT,  junk | c.in_zero_point);
        write_reg(REG_IN_SCALE,       c.in_scale);
        write_reg(REG_OUT_ZERO_POINT, junk | c.out_zero_point);
        write_reg(REG_INV_OUT_SCALE,  c.inv_out_scale);
        write_reg(REG_OUT_MIN,        junk | c.out_min);
        write_reg(REG_OUT_MAX,        junk | c.out_max);
        end_writes();
        settings_applied++;
    endtask

    // offer one sample after a random gap, record its activation on acceptance
    task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
        activation_check_t item;
        while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        do @(posedge aclk); while (!s_tready);
        item.sample     = sample;
        item.activation = quantized_hardswish(sample, active_cfg);
        pending_activations.push_back(item);
        samples_sent++;
    endtask

    // receiver: random idling plus requested long hold-offs
    always @(posedge aclk) begin : result_sink
        int unsigned hold_left;
        int unsigned hold_seen;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left = 0;
            hold_seen = hold_off_requests;
        end else begin
            if (hold_off_requests != hold_seen) begin
                hold_seen = hold_off_requests;
                hold_left = HOLD_OFF_LEN;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            end
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : result_check
        activation_check_t head;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_activations.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected activation %0d with no sample outstanding", m_tdata);
            end else begin
                head = pending_activations.pop_front();
                results_checked++;
                if (m_tdata !== head.activation) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("activation mismatch: sample %0d expected %0d actual %0d",
                                 head.sample, head.activation, m_tdata);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_activations.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // reset values with no register written
    task automatic test_power_on_defaults();
        send_sample(8'd0);
        send_sample(8'd1);
        send_sample(8'd2);
        send_sample(8'd3);
        send_sample(8'd255);
    endtask

    // zero region, boundary at -3, negative and positive curve, pass-through at +3
    task automatic test_dequant_regions();
        cfg_t c;
        c = RESET_CFG;
        c.in_zero_point  = 8'd128;
        c.out_zero_point = 8'd128;
        apply_config(c, 1'b0);
        send_sample(8'd0);
        send_sample(8'd125);
        send_sample(8'd126);
        send_sample(8'd127);
        send_sample(8'd130);
        send_sample(8'd131);
    endtask

    // output scale of one half puts odd inputs exactly on a tie
    task automatic test_round_half_even();
        cfg_t c;
        c = RESET_CFG;
        c.inv_out_scale = SCALE_HALF;
        apply_config(c, 1'b0);
        send_sample(8'd3);
        send_sample(8'd5);
        send_sample(8'd7);
    endtask

    // zero scales collapse the result onto the output zero point
    task automatic test_zero_scales();
        cfg_t c;
        c = RESET_CFG;
        c.in_scale       = '0;
        c.out_zero_point = 8'd255;
        c.in_zero_point  = 8'd255;
        apply_config(c, 1'b0);
        send_sample(8'd200);
        c.in_scale       = SCALE_ONE;
        c.inv_out_scale  = '0;
        c.out_zero_point = 8'd77;
        apply_config(c, 1'b0);
        send_sample(8'd0);
    endtask

    // largest scales: products just under and just over 64 bits
    task automatic test_product_saturation();
        cfg_t c;
        c = RESET_CFG;
        c.in_scale      = SCALE_MAX;
        c.inv_out_scale = SCALE_MAX;
        c.out_zero_point = 8'd5;
        c.out_max       = 8'd200;
        apply_config(c, 1'b0);
        send_sample(8'd1);
        send_sample(8'd2);
        send_sample(8'd255);
    endtask

    // out_min above out_max pins every result to out_max
    task automatic test_inverted_bounds();
        cfg_t c;
        c = RESET_CFG;
        c.out_min = 8'd200;
        c.out_max = 8'd50;
        apply_config(c, 1'b0);
        send_sample(8'd0);
        send_sample(8'd255);
    endtask

    // writes to unmapped indexes leave the register set untouched
    task automatic test_unmapped_register();
        wait_idle();
        write_reg(REG_UNMAPPED_LO, 32'hFFFF_FFFF);
        write_reg(REG_UNMAPPED_HI, 32'h0000_0000);
        end_writes();
        send_sample(8'd10);
    endtask

    function automatic logic [SCALE_W-1:0] pick_scale(input logic [SCALE_W-1:0] lo,
                                                      input logic [SCALE_W-1:0] hi);
        case ($urandom_range(0, 9))
            0:       return 32'd1;
            1:       return SCALE_MAX;
            2:       return $urandom();
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    function automatic cfg_t random_config();
        cfg_t        c;
        logic [7:0]  b0, b1;
        c.in_zero_point  = 8'($urandom_range(0, 255));
        c.out_zero_point = 8'($urandom_range(0, 255));
        c.in_scale       = pick_scale(32'h0001_0000, 32'h0400_0000);
        c.inv_out_scale  = pick_scale(32'h0040_0000, 32'h4000_0000);
        b0 = 8'($urandom_range(0, 255));
        b1 = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0, 1: begin
                c.out_min = 8'd0;
                c.out_max = 8'd255;
            end
            2: begin
                // occasionally inverted
                c.out_min = b0;
                c.out_max = b1;
            end
            default: begin
                c.out_min = (b0 < b1) ? b0 : b1;
                c.out_max = (b0 < b1) ? b1 : b0;
            end
        endcase
        return c;
    endfunction

    // random settings, samples uniform or clustered around the input zero point
    task automatic test_random_stream(input int unsigned send_pct, input int unsigned recv_pct,
                                      input int unsigned n_settings, input int unsigned n_items);
        int          v;
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        for (int s = 0; s < n_settings; s++) begin
            apply_config(random_config(), 1'b1);
            for (int i = 0; i < n_items; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    v = int'(active_cfg.in_zero_point) + $urandom_range(0, 12) - 6;
                    if (v < 0)   v = 0;
                    if (v > 255) v = 255;
                end else begin
                    v = $urandom_range(0, 255);
                end
                send_sample(v[7:0]);
            end
        end
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_output_backpressure();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        apply_config(random_config(), 1'b0);
        hold_off_requests++;
        for (int i = 0; i < 80; i++)
            send_sample(8'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        sender_idle_pct   = 28;
        receiver_idle_pct = 83;
        test_power_on_defaults();
        test_dequant_regions();
        test_round_half_even();
        test_zero_scales();
        test_product_saturation();
        test_inverted_bounds();
        test_unmapped_register();

        test_random_stream(28, 83, 10, 52);
        test_random_stream(83, 28, 10, 52);
        test_random_stream(0, 0, 10, 52);
        test_output_backpressure();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d samples across %0d register settings, %0d activations checked",
                 samples_sent, settings_applied, results_checked);
        $display("directed regions, ties, zero scales, saturation, inverted bounds, hold-off");
        if (mismatch_count == 0 && pending_activations.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d activations missing",
                     mismatch_count, pending_activations.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== quantized_hardswish_unit.f =====
rtl/core/qhs_pkg.sv
rtl/core/qhs_dequant.sv
rtl/core/qhs_hswish.sv
rtl/core/qhs_requant.sv
rtl/core/quantized_hardswish_unit.sv
tb/tb_quantized_hardswish_unit.sv
